/* rtl/core/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int TICK_W    = 32;
  localparam int MS_W      = 16;
  localparam int PERIOD_W  = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int EVT_W     = 3;

  // Elapsed milliseconds, saturated: the top value means "65536 or more".
  localparam int ELAPSED_W = MS_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [MS_W-1:0]     RST_DEBOUNCE  = 16'd20;
  localparam logic [MS_W-1:0]     RST_LONG      = 16'd3000;
  localparam logic [MS_W-1:0]     RST_VERY_LONG = 16'd5000;
  localparam logic [MS_W-1:0]     RST_WINDOW    = 16'd400;
  localparam logic [PERIOD_W-1:0] RST_PERIOD    = 10'd1;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE      = 3'd0,
    EV_SHORT     = 3'd1,
    EV_DOUBLE    = 3'd2,
    EV_LONG      = 3'd3,
    EV_VERY_LONG = 3'd4
  } event_t;

  typedef struct packed {
    logic [MS_W-1:0]     debounce_ms;
    logic [MS_W-1:0]     long_ms;
    logic [MS_W-1:0]     very_long_ms;
    logic [MS_W-1:0]     double_window_ms;
    logic [PERIOD_W-1:0] tick_period_ms;
  } cfg_t;

  typedef struct packed {
    logic              press_edge;
    logic              pin_level;
    logic [TICK_W-1:0] now_tick;
  } poll_t;

endpackage

/* rtl/core/bpc_elapsed.sv */
// ----------------------------------------------------------------------------
// bpc_elapsed
// Wrapping tick difference scaled to milliseconds, saturated above 16 bits.
// ----------------------------------------------------------------------------
module bpc_elapsed
  import bpc_pkg::*;
(
  input  logic [TICK_W-1:0]    now_tick,
  input  logic [TICK_W-1:0]    since_tick,
  input  logic [PERIOD_W-1:0]  period,
  output logic [ELAPSED_W-1:0] elapsed_ms
);

  localparam int PROD_W = MS_W + PERIOD_W;

  logic [TICK_W-1:0] diff;
  logic [PROD_W-1:0] prod;
  logic              sat;

  assign diff = now_tick - since_tick;
  assign prod = PROD_W'(diff[MS_W-1:0]) * PROD_W'(period);

  // Every threshold fits in 16 bits, so any product of 2^16 or more only
  // needs to be known as "large". A zero period keeps every time at zero.
  assign sat = (period != '0) &&
               ((diff[TICK_W-1:MS_W] != '0) || (prod[PROD_W-1:MS_W] != '0));

  assign elapsed_ms = sat ? {1'b1, {MS_W{1'b0}}} : {1'b0, prod[MS_W-1:0]};

endmodule

/* rtl/core/bpc_classify.sv */
// ----------------------------------------------------------------------------
// bpc_classify
// Press tracking state and the per-poll event decision.
// ----------------------------------------------------------------------------
module bpc_classify
  import bpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  poll_t  poll,
  input  logic   step_en,
  output event_t event_res
);

  logic              held_r, held_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;
  logic              await_r, await_nxt;
  logic [TICK_W-1:0] srt_r, srt_nxt;
  logic              long_r, long_nxt;
  logic              vlong_r, vlong_nxt;

  logic [ELAPSED_W-1:0] hold_ms;
  logic [ELAPSED_W-1:0] win_ms;
  logic                 held_now;
  logic                 bounce;
  logic                 srt_set;
  logic                 win_done;
  logic                 ge_deb, ge_long, ge_vlong;
  event_t               ev;

  // A fresh press starts at this poll's tick.
  always_comb begin
    held_now  = held_r;
    start_nxt = start_r;
    if (poll.press_edge && !held_r) begin
      held_now  = 1'b1;
      start_nxt = poll.now_tick;
    end
  end

  bpc_elapsed u_hold (
    .now_tick   (poll.now_tick),
    .since_tick (start_nxt),
    .period     (cfg.tick_period_ms),
    .elapsed_ms (hold_ms)
  );

  bpc_elapsed u_window (
    .now_tick   (poll.now_tick),
    .since_tick (srt_r),
    .period     (cfg.tick_period_ms),
    .elapsed_ms (win_ms)
  );

  assign ge_deb   = hold_ms >= {1'b0, cfg.debounce_ms};
  assign ge_long  = hold_ms >= {1'b0, cfg.long_ms};
  assign ge_vlong = hold_ms >= {1'b0, cfg.very_long_ms};

  always_comb begin
    held_nxt  = held_now;
    await_nxt = await_r;
    srt_nxt   = srt_r;
    long_nxt  = long_r;
    vlong_nxt = vlong_r;
    bounce    = 1'b0;
    srt_set   = 1'b0;
    ev        = EV_NONE;

    if (held_now) begin
      if (poll.pin_level) begin
        held_nxt = 1'b0;
        long_nxt = 1'b0;
        priority if (!ge_deb) begin
          bounce = 1'b1;
        end else if (ge_vlong) begin
          await_nxt = 1'b0;
          if (!vlong_r) begin
            ev = EV_VERY_LONG;
          end
          vlong_nxt = 1'b0;
        end else if (!ge_long) begin
          if (await_r) begin
            await_nxt = 1'b0;
            ev        = EV_DOUBLE;
          end else begin
            await_nxt = 1'b1;
            srt_nxt   = poll.now_tick;
            srt_set   = 1'b1;
          end
        end else begin
          // A release between the long and very long thresholds is silent.
        end
      end else begin
        priority if (ge_vlong && !vlong_r) begin
          await_nxt = 1'b0;
          vlong_nxt = 1'b1;
          ev        = EV_VERY_LONG;
        end else if (ge_long && !long_r) begin
          await_nxt = 1'b0;
          long_nxt  = 1'b1;
          ev        = EV_LONG;
        end else begin
          // Still held with nothing new to report.
        end
      end
    end

    // A window opened on this very poll has zero elapsed time.
    win_done = srt_set ? (cfg.double_window_ms == '0)
                       : (win_ms >= {1'b0, cfg.double_window_ms});
    if (!bounce && await_nxt && win_done) begin
      await_nxt = 1'b0;
      ev        = EV_SHORT;
    end
  end

  assign event_res = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      start_r <= '0;
      await_r <= 1'b0;
      srt_r   <= '0;
      long_r  <= 1'b0;
      vlong_r <= 1'b0;
    end else if (step_en) begin
      held_r  <= held_nxt;
      start_r <= start_nxt;
      await_r <= await_nxt;
      srt_r   <= srt_nxt;
      long_r  <= long_nxt;
      vlong_r <= vlong_nxt;
    end
  end

`ifndef SYNTH
  a_double_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (ev == EV_DOUBLE) |-> await_r)
    else $error("double click without an open window");

  a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (ev == EV_LONG) |=> long_r && held_r)
    else $error("long press not recorded as reported");

  a_vlong_closes_window: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (ev == EV_VERY_LONG) |=> !await_r)
    else $error("window still open after very long press");

  a_short_closes_window: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (ev == EV_SHORT) |=> !await_r)
    else $error("window still open after short press");
`endif

endmodule

/* rtl/core/button_press_classifier_top.sv */
// ----------------------------------------------------------------------------
// button_press_classifier_top
// Classifies button presses from periodic polls into short, double, long
// and very long events.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the in_ channel is one poll: the latched falling-edge
//   flag, the pin level (1 = released) and the free-running tick. Every poll
//   gives exactly one transfer on the out_ channel carrying out_event_res
//   (0 when nothing happened on that poll).
//   The poll is captured in an input register and classified from there
//   into the result register; one poll is taken every cycle while out_ready
//   stays high. The press state updates as each poll moves into the result
//   register. The hold time comes from one 16 by 10 bit multiply.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready then drops until out_ready returns.
//   Synchronous reset empties both registers, clears the press state and
//   loads the default thresholds. Configuration writes (cfg_we, cfg_index,
//   cfg_wdata) take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module button_press_classifier_top
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_press_edge,
  input  logic                 in_pin_level,
  input  logic [TICK_W-1:0]    in_now_tick,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [EVT_W-1:0]     out_event_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  poll_t  poll_r;
  logic   poll_valid_r;
  logic   out_valid_r;
  event_t out_event_r;
  event_t event_res;
  logic   advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= RST_DEBOUNCE;
      cfg_r.long_ms          <= RST_LONG;
      cfg_r.very_long_ms     <= RST_VERY_LONG;
      cfg_r.double_window_ms <= RST_WINDOW;
      cfg_r.tick_period_ms   <= RST_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  cfg_r.debounce_ms      <= cfg_wdata;
        CFG_LONG:      cfg_r.long_ms          <= cfg_wdata;
        CFG_VERY_LONG: cfg_r.very_long_ms     <= cfg_wdata;
        CFG_WINDOW:    cfg_r.double_window_ms <= cfg_wdata;
        CFG_PERIOD:    cfg_r.tick_period_ms   <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // A poll moves on whenever the result register is empty or being drained.
  assign advance  = poll_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !poll_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
    end else if (in_ready) begin
      poll_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r.press_edge <= in_press_edge;
      poll_r.pin_level  <= in_pin_level;
      poll_r.now_tick   <= in_now_tick;
    end
  end

  bpc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .poll      (poll_r),
    .step_en   (advance),
    .event_res (event_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r <= event_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;

endmodule

/* test/button_press_classifier_top_tb.sv */
// ----------------------------------------------------------------------------
// button_press_classifier_top_tb
// Drives polls into the button press classifier and checks every event.
// A directed run at the reset thresholds comes first. It is followed by
// phases of random press sequences and noise under several threshold
// settings. Each accepted poll is classified by a software copy of the
// press state machine, and the predicted events are compared in order
// with the result channel.
// ----------------------------------------------------------------------------
module button_press_classifier_top_tb;
  import bpc_pkg::*;

  class press_event_scoreboard;
    logic [MS_W-1:0]     thr_debounce;
    logic [MS_W-1:0]     thr_long;
    logic [MS_W-1:0]     thr_very_long;
    logic [MS_W-1:0]     win_double;
    logic [PERIOD_W-1:0] period;
    bit                  pressed;
    bit [TICK_W-1:0]     t_press;
    bit                  window_open;
    bit [TICK_W-1:0]     t_release;
    bit                  long_sent;
    bit                  very_long_sent;
    event_t              events_due[$];
    int                  errors;

    function void clear();
      thr_debounce   = RST_DEBOUNCE;
      thr_long       = RST_LONG;
      thr_very_long  = RST_VERY_LONG;
      win_double     = RST_WINDOW;
      period         = RST_PERIOD;
      pressed        = 1'b0;
      t_press        = '0;
      window_open    = 1'b0;
      t_release      = '0;
      long_sent      = 1'b0;
      very_long_sent = 1'b0;
      events_due.delete();
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_DEBOUNCE:  thr_debounce  = val;
        CFG_LONG:      thr_long      = val;
        CFG_VERY_LONG: thr_very_long = val;
        CFG_WINDOW:    win_double    = val;
        CFG_PERIOD:    period        = val[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact hold time in ms; the tick difference wraps modulo 2^32.
    function longint unsigned span_ms(bit [TICK_W-1:0] now, bit [TICK_W-1:0] since);
      bit [TICK_W-1:0] d;
      d = now - since;
      return longint'(d) * longint'(period);
    endfunction

    function void note_poll(bit edge_seen, bit released, bit [TICK_W-1:0] now);
      event_t          ev;
      longint unsigned held;
      ev = EV_NONE;
      if (edge_seen && !pressed) begin
        t_press = now;
        pressed = 1'b1;
      end
      if (pressed) begin
        held = span_ms(now, t_press);
        if (released) begin
          pressed   = 1'b0;
          long_sent = 1'b0;
          if (held < thr_debounce) begin
            // A bounce ends the poll before the window check.
            events_due.push_back(EV_NONE);
            return;
          end
          if (held >= thr_very_long) begin
            window_open = 1'b0;
            if (!very_long_sent) ev = EV_VERY_LONG;
            very_long_sent = 1'b0;
          end else if (held < thr_long) begin
            if (window_open) begin
              window_open = 1'b0;
              ev = EV_DOUBLE;
            end else begin
              window_open = 1'b1;
              t_release   = now;
            end
          end
        end else if (held >= thr_very_long && !very_long_sent) begin
          window_open    = 1'b0;
          very_long_sent = 1'b1;
          ev = EV_VERY_LONG;
        end else if (held >= thr_long && !long_sent) begin
          window_open = 1'b0;
          long_sent   = 1'b1;
          ev = EV_LONG;
        end
      end
      if (window_open && span_ms(now, t_release) >= win_double) begin
        window_open = 1'b0;
        ev = EV_SHORT;
      end
      events_due.push_back(ev);
    endfunction

    function void check_event(logic [EVT_W-1:0] act);
      event_t want;
      if (events_due.size() == 0) begin
        $error("event_res: no event expected, actual %0d", act);
        errors++;
        return;
      end
      want = events_due.pop_front();
      if (act !== want) begin
        $error("event_res mismatch: expected %0d, actual %0d", want, act);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_press_edge = 1'b0;
  logic                 in_pin_level = 1'b1;
  logic [TICK_W-1:0]    in_now_tick = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [EVT_W-1:0]     out_event_res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  press_event_scoreboard sb = new();

  bit [TICK_W-1:0] tick;
  int              polls_sent;
  bit              tx_calm;
  bit              rx_calm;
  int              stall_asks;
  int              stalls_taken;
  int              stall_left;

  button_press_classifier_top DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold-off when asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_asks != stalls_taken) begin
      stalls_taken <= stalls_taken + 1;
      stall_left   <= 80;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= rx_calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_event(out_event_res);
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_poll(input bit edge_seen, input bit released, input bit [TICK_W-1:0] t);
    if (!tx_calm) begin
      while ($urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_press_edge <= edge_seen;
    in_pin_level  <= released;
    in_now_tick   <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_poll(edge_seen, released, t);
    polls_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [MS_W-1:0] deb, input logic [MS_W-1:0] lng,
                                input logic [MS_W-1:0] vlng, input logic [MS_W-1:0] win,
                                input logic [PERIOD_W-1:0] per);
    logic [CFG_IDX_W-1:0] idx[5];
    logic [CFG_DAT_W-1:0] val[5];
    idx = '{CFG_DEBOUNCE, CFG_LONG, CFG_VERY_LONG, CFG_WINDOW, CFG_PERIOD};
    val = '{deb, lng, vlng, win, CFG_DAT_W'(per)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Hold times are aimed at the thresholds, where the decisions change.
  function automatic int unsigned pick_hold_ms();
    int v;
    case ($urandom_range(0, 8))
      0: v = int'(sb.thr_debounce) - 1;
      1: v = int'(sb.thr_debounce);
      2: v = int'(sb.thr_long) - 1;
      3: v = int'(sb.thr_long);
      4: v = int'(sb.thr_very_long) - 1;
      5: v = int'(sb.thr_very_long);
      6: v = $urandom_range(0, 70000);
      default: v = $urandom_range(sb.thr_debounce, sb.thr_long);
    endcase
    return (v < 0) ? 0 : v;
  endfunction

  function automatic int unsigned pick_gap_ms();
    case ($urandom_range(0, 4))
      0: return 32'(sb.win_double);
      1: return (sb.win_double == 0) ? 0 : 32'(sb.win_double) - 1;
      2: return 32'(sb.win_double) + 1;
      3: return $urandom_range(0, 2 * 32'(sb.win_double));
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned ms_to_ticks(int unsigned ms);
    int unsigned t;
    if (sb.period == 0) return $urandom_range(0, 40);
    t = (ms + sb.period - 1) / sb.period;
    case ($urandom_range(0, 3))
      0: return (t == 0) ? 0 : t - 1;
      1: return t + 1;
      default: return t;
    endcase
  endfunction

  // One press: the edge, up to three polls while held, the release, up to two more released polls, then a gap.
  task automatic press_sequence();
    int unsigned hold_t;
    int unsigned prev;
    int unsigned n_mid;
    hold_t = ms_to_ticks(pick_hold_ms());
    prev   = 0;
    send_poll(1'b1, 1'b0, tick);
    n_mid = $urandom_range(0, 3);
    for (int k = 0; k < n_mid; k++) begin
      prev = prev + $urandom_range(0, hold_t - prev);
      send_poll($urandom_range(0, 3) == 0, 1'b0, tick + prev);
    end
    tick += hold_t;
    send_poll(1'b0, 1'b1, tick);
    repeat ($urandom_range(0, 2)) begin
      tick += ms_to_ticks(pick_gap_ms());
      send_poll(1'b0, 1'b1, tick);
    end
    tick += ms_to_ticks(pick_gap_ms());
  endtask

  task automatic random_phase(input int count);
    int unsigned goal;
    bit [TICK_W-1:0] noise_tick;
    goal = polls_sent + count;
    while (polls_sent < goal) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          tick += $urandom_range(0, 3);
          send_poll(1'b0, 1'b1, tick);
        end
        2, 3: begin
          // Noise, and now and then a jump of the tick across the wrap.
          noise_tick = $urandom();
          send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), noise_tick);
          if ($urandom_range(0, 1)) tick = noise_tick;
        end
        default: press_sequence();
      endcase
    end
    settle();
  endtask

  task automatic directed_polls();
    send_poll(1'b0, 1'b1, 32'd0);
    send_poll(1'b1, 1'b0, 32'd100);
    send_poll(1'b0, 1'b1, 32'd110);
    send_poll(1'b0, 1'b1, 32'd115);
    send_poll(1'b1, 1'b0, 32'd200);
    send_poll(1'b0, 1'b1, 32'd300);
    send_poll(1'b0, 1'b1, 32'd350);
    send_poll(1'b1, 1'b0, 32'd400);
    send_poll(1'b0, 1'b1, 32'd450);
    send_poll(1'b1, 1'b0, 32'd1000);
    send_poll(1'b0, 1'b1, 32'd1100);
    send_poll(1'b0, 1'b1, 32'd1600);
    // Held through long and very long, with an edge while held.
    send_poll(1'b1, 1'b0, 32'd2000);
    send_poll(1'b1, 1'b0, 32'd2500);
    send_poll(1'b0, 1'b0, 32'd5000);
    send_poll(1'b0, 1'b0, 32'd7000);
    send_poll(1'b0, 1'b1, 32'd8000);
    send_poll(1'b1, 1'b0, 32'd10000);
    send_poll(1'b0, 1'b1, 32'd16000);
    send_poll(1'b1, 1'b0, 32'd20000);
    send_poll(1'b0, 1'b1, 32'd24000);
    // A short press across the tick wrap.
    send_poll(1'b1, 1'b0, 32'hFFFF_FFF0);
    send_poll(1'b0, 1'b1, 32'h0000_0010);
    send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 1'b1, 32'd100);
    tick = 32'd1000;
    settle();
  endtask

  initial begin
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_polls();
    random_phase(150);

    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 10'd1);
    random_phase(60);

    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1000);
    random_phase(120);

    // No idling on either side, except one long hold-off by the receiver.
    apply_settings(16'd30, 16'd500, 16'd1200, 16'd300, 10'd7);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    stall_asks++;
    random_phase(200);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Very long threshold below the long one.
    apply_settings(16'd400, 16'd2000, 16'd900, 16'd50, 10'd3);
    random_phase(130);

    // With a zero period every hold and window time is zero.
    apply_settings(16'd0, 16'd3, 16'd5, 16'd10, 10'd0);
    random_phase(50);

    repeat (3) begin
      apply_settings(MS_W'($urandom_range(0, 200)), MS_W'($urandom_range(0, 6000)),
                     MS_W'($urandom_range(0, 9000)), MS_W'($urandom_range(0, 1000)),
                     PERIOD_W'($urandom_range(1, 1000)));
      random_phase(70);
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* button_press_classifier_top.f */
rtl/core/bpc_pkg.sv
rtl/core/bpc_elapsed.sv
rtl/core/bpc_classify.sv
rtl/core/button_press_classifier_top.sv
test/button_press_classifier_top_tb.sv
